[rtl/lpl_pkg.sv]
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types, constants and helpers for the lighthouse pulse localizer.
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int WINDOW  = 5;
    localparam int WIN_AW  = $clog2(WINDOW);
    localparam int WIN_CW  = $clog2(WINDOW + 1);
    localparam int STAMP_W = 24;
    localparam int SLOT_W  = 40;
    localparam int DIV_W   = 64;
    localparam int DIV_CW  = $clog2(DIV_W + 1);
    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam logic [STAMP_W-1:0] STAMP_MAX = 24'hFFFFFF;
    localparam logic [29:0] AXIS_MUL   = 30'd48;
    localparam logic [63:0] AXIS_BASE  = 64'd2501;
    // v/500 == ((v >> 2) * AXIS_RCP) >> 20 for every 16-bit v
    localparam logic [13:0] AXIS_RCP   = 14'd8389;
    localparam logic [63:0] PI_Q16     = 64'd205887;
    localparam logic [63:0] OFFN_H     = 64'd19818 * PI_Q16;
    localparam logic [63:0] OFFN_V     = 64'd58989 * PI_Q16;
    localparam logic [63:0] C1N_H      = 64'd1199250 << 32;
    localparam logic [63:0] C1N_V      = 64'd1061080 << 32;
    localparam logic [63:0] E_H        = 64'd14536;
    localparam logic [63:0] E_V        = 64'd20146;
    localparam logic [63:0] ANGLE_MAX  = 64'd65535;
    localparam logic [63:0] RANGE_MAX  = 64'hFFFFFF;

    typedef enum logic { OP_PULSE = 1'b0, OP_LOCATE = 1'b1 } t_op;

    typedef enum logic [1:0] {
        REG_CLOCK     = 2'd0,
        REG_MIN_SYNC  = 2'd1,
        REG_MAX_SYNC  = 2'd2,
        REG_PERIOD    = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLS, ST_AX1, ST_AX2, ST_CHK,
        ST_ANG, ST_TDIV, ST_ODIV, ST_QDIV, ST_OUT
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [STAMP_W-1:0] rise;
        logic [STAMP_W-1:0] fall;
        logic [SLOT_W-1:0]  slot;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  clock_mhz;   // zero already mapped to one
        logic [9:0]  min_sync_us;
        logic [9:0]  max_sync_us;
        logic [15:0] period_us;   // zero already mapped to one
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic               fix_valid;
        logic [15:0]        azimuth;
        logic [15:0]        elevation;
        logic [STAMP_W-1:0] range_horiz;
        logic [STAMP_W-1:0] range_vert;
        logic [SLOT_W-1:0]  slot_echo;
    } t_fix;

    // Tick distance from a to b with 24-bit wrap (one tick short on wrap).
    function automatic logic [STAMP_W-1:0] span(input logic [STAMP_W-1:0] a,
                                                input logic [STAMP_W-1:0] b);
        logic [STAMP_W-1:0] diff;
        begin
            diff = b - a;
            return (a > b) ? diff - 24'd1 : diff;
        end
    endfunction

endpackage

[rtl/lpl_if.sv]
// ----------------------------------------------------------------------------
// lpl_if
// Valid/ready channels for pulse beats in and fix beats out.
// ----------------------------------------------------------------------------
interface lpl_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [23:0] rise_ticks;
    logic [23:0] fall_ticks;
    logic [39:0] slot_number;
    modport source (output valid, func, rise_ticks, fall_ticks, slot_number,
                    input ready);
    modport sink   (input valid, func, rise_ticks, fall_ticks, slot_number,
                    output ready);
endinterface

interface lpl_out_if;
    logic        valid;
    logic        ready;
    logic        fix_valid;
    logic [15:0] azimuth;
    logic [15:0] elevation;
    logic [23:0] range_horiz;
    logic [23:0] range_vert;
    logic [39:0] slot_echo;
    modport source (output valid, fix_valid, azimuth, elevation, range_horiz,
                    range_vert, slot_echo, input ready);
    modport sink   (input valid, fix_valid, azimuth, elevation, range_horiz,
                    range_vert, slot_echo, output ready);
endinterface

[rtl/lighthouse_pulse_localizer_unit.sv]
// ----------------------------------------------------------------------------
// lighthouse_pulse_localizer_unit
// Stores light pulse stamps and turns a window of them into an angle/range fix.
// ----------------------------------------------------------------------------
// Pulse beats: the ring is written when the back end, while idle, pops the beat.
// Localize beats: each quotient comes from the single shared 64-bit restoring
//   divider (one for axis decode per sweep, up to 4 per axis for angle and
//   distance).
// The two-entry command queue keeps accepting while the back end works, until full.
// Reset (synchronous, active low): ring and write slot cleared, registers at
//   their defaults, queue and result register empty.
// ----------------------------------------------------------------------------
module lighthouse_pulse_localizer_unit
    import lpl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpl_in_if.sink      i_pulse,
    lpl_out_if.source   o_fix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [7:0]  r_clock_mhz;
    logic [9:0]  r_min_sync;
    logic [9:0]  r_max_sync;
    logic [15:0] r_period;
    logic        cfg_wr;
    t_reg        reg_sel;
    t_cfg        cfg;

    logic        cmd_valid, cmd_pop;
    t_cmd        cmd;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_mhz <= 8'd32;
            r_min_sync  <= 10'd50;
            r_max_sync  <= 10'd140;
            r_period    <= 16'd8333;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_CLOCK:    r_clock_mhz <= pwdata[7:0];
                REG_MIN_SYNC: r_min_sync  <= pwdata[9:0];
                REG_MAX_SYNC: r_max_sync  <= pwdata[9:0];
                REG_PERIOD:   r_period    <= pwdata[15:0];
                default:      r_period    <= r_period;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_CLOCK:    prdata = {24'd0, r_clock_mhz};
            REG_MIN_SYNC: prdata = {22'd0, r_min_sync};
            REG_MAX_SYNC: prdata = {22'd0, r_max_sync};
            REG_PERIOD:   prdata = {16'd0, r_period};
            default:      prdata = '0;
        endcase
    end

    // zero clock or period behaves as one
    always_comb begin
        cfg.clock_mhz   = (r_clock_mhz == '0) ? 8'd1 : r_clock_mhz;
        cfg.min_sync_us = r_min_sync;
        cfg.max_sync_us = r_max_sync;
        cfg.period_us   = (r_period == '0) ? 16'd1 : r_period;
    end

    // front: accept and decode beats into the command queue
    lpl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pulse     (i_pulse),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // shared serial divider
    lpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // back: ring storage, window walk, fix math, result register
    lpl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (cfg),
        .o_div       (div_req),
        .i_div       (div_rsp),
        .o_fix       (o_fix)
    );

endmodule

[rtl/lpl_front.sv]
// ----------------------------------------------------------------------------
// lpl_front
// Accepts beats, decodes the operation and queues commands for the back end.
// ----------------------------------------------------------------------------
module lpl_front
    import lpl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpl_in_if.sink    i_pulse,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  logic      i_cmd_pop
);

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             push;
    t_cmd             cmd_in;

    assign i_pulse.ready = (r_cnt != QCW'(QDEPTH));
    assign push          = i_pulse.valid && i_pulse.ready;
    assign o_cmd_valid   = (r_cnt != '0);
    assign o_cmd         = r_mem[r_rd];

    always_comb begin
        cmd_in.op   = i_pulse.func ? OP_LOCATE : OP_PULSE;
        cmd_in.rise = i_pulse.rise_ticks;
        cmd_in.fall = i_pulse.fall_ticks;
        cmd_in.slot = i_pulse.slot_number;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd <= (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(push) - QCW'(i_cmd_pop);
        end
    end

endmodule

[rtl/lpl_div.sv]
// ----------------------------------------------------------------------------
// lpl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpl_div
    import lpl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]  r_rem, r_quo, r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [DIV_W:0]    sh, diff;
    logic              fits;

    assign sh   = {r_rem, r_quo[DIV_W-1]};
    assign diff = sh - {1'b0, r_den};
    assign fits = (sh >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/lpl_back.sv]
// ----------------------------------------------------------------------------
// lpl_back
// Pulse ring, window walk sequencer and fix arithmetic on the shared divider.
// ----------------------------------------------------------------------------
module lpl_back
    import lpl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    input  t_cfg      i_cfg,
    output t_div_req  o_div,
    input  t_div_rsp  i_div,
    lpl_out_if.source o_fix
);

    t_state              r_state, n_state;
    logic [47:0]         r_ring [WINDOW];
    logic [WIN_AW-1:0]   r_wslot, r_ptr;
    logic [WIN_CW-1:0]   r_idx, r_first;
    logic                r_ok, r_wait, r_vert, r_neg;
    logic [2:0]          r_sum;
    logic [STAMP_W-1:0]  r_prev_w, r_prev_f, r_cur_w, r_cur_g, r_cur_f;
    logic [STAMP_W-1:0]  r_gh, r_wh, r_gv, r_wv;
    logic [15:0]         r_v, r_az, r_el;
    logic [STAMP_W-1:0]  r_rh, r_rv;
    logic [DIV_W-1:0]    r_t, r_d;
    logic [SLOT_W-1:0]   r_slot;
    t_fix                r_out;
    logic                r_out_valid;

    logic [47:0]         entry;
    logic [STAMP_W-1:0]  e_rise, e_fall, w_cur, g_cur, g_sel, w_sel;
    logic [17:0]         thr_min, thr_max;
    logic                is_sweep, is_sync, has_first, k_ok, last;
    logic [WIN_CW-1:0]   k;
    logic [29:0]         prod48;
    logic [23:0]         cp;
    logic [DIV_W-1:0]    offn, c1n, e_val, q, d_val, rr, vq;
    logic                d_neg, d_zero, out_free, final_ok;
    logic [27:0]         v_prod;
    logic [1:0]          ax;

    // ---------------- datapath decode ----------------
    always_comb begin
        entry     = r_ring[r_ptr];
        e_rise    = entry[23:0];
        e_fall    = entry[47:24];
        w_cur     = span(e_rise, e_fall);
        g_cur     = span(r_prev_f, e_rise);
        thr_min   = {8'd0, i_cfg.min_sync_us} * {10'd0, i_cfg.clock_mhz};
        thr_max   = {8'd0, i_cfg.max_sync_us} * {10'd0, i_cfg.clock_mhz};
        is_sweep  = w_cur < {6'd0, thr_min};
        is_sync   = !is_sweep && (w_cur < {6'd0, thr_max});
        has_first = (r_first != WIN_CW'(WINDOW));
        k         = r_idx - r_first;
        k_ok      = (k == WIN_CW'(1)) || (k == WIN_CW'(3));
        last      = (r_idx == WIN_CW'(WINDOW - 1));
        prod48    = {6'd0, r_prev_w} * AXIS_MUL;
        cp        = {16'd0, i_cfg.clock_mhz} * {8'd0, i_cfg.period_us};
        g_sel     = r_vert ? r_gv : r_gh;
        w_sel     = r_vert ? r_wv : r_wh;
        offn      = r_vert ? OFFN_V : OFFN_H;
        c1n       = r_vert ? C1N_V : C1N_H;
        e_val     = r_vert ? E_V : E_H;
        q         = i_div.quo;
        vq        = q - AXIS_BASE;
        // axis bit is the parity of v/500; bit 20 is the quotient's LSB
        v_prod    = {14'd0, r_v[15:2]} * {14'd0, AXIS_RCP};
        ax        = v_prod[20] ? 2'd2 : 2'd1;
        final_ok  = r_ok && has_first && (r_sum == 3'd3);
        out_free  = !r_out_valid || o_fix.ready;
        // fitted distance denominator; quotient holds the offset term here
        d_neg = 1'b0;
        if (!r_vert) begin
            d_val = r_t + q;
        end else if (r_t >= q) begin
            d_val = r_t - q;
        end else begin
            d_val = q - r_t;
            d_neg = 1'b1;
        end
        d_zero = (d_val == '0);
        // range from reciprocal quotient
        if (r_neg) begin
            rr = (q >= e_val) ? '0 : e_val - q;
        end else begin
            rr = e_val + q;
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_LOCATE) begin
                    n_state = ST_CLS;
                end
            end
            ST_CLS: begin
                if (!is_sweep && !is_sync) begin
                    n_state = ST_OUT;
                end else if (is_sweep && has_first) begin
                    n_state = k_ok ? ST_AX1 : ST_OUT;
                end else if (last) begin
                    n_state = ST_CHK;
                end
            end
            ST_AX1:  if (i_div.done) n_state = ST_AX2;
            ST_AX2:  n_state = last ? ST_CHK : ST_CLS;
            ST_CHK:  n_state = final_ok ? ST_ANG : ST_OUT;
            ST_ANG:  if (i_div.done) n_state = ST_TDIV;
            ST_TDIV: if (i_div.done) n_state = ST_ODIV;
            ST_ODIV: begin
                if (i_div.done) begin
                    if (!d_zero) n_state = ST_QDIV;
                    else         n_state = r_vert ? ST_OUT : ST_ANG;
                end
            end
            ST_QDIV: if (i_div.done) n_state = r_vert ? ST_OUT : ST_ANG;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        o_cmd_pop   = (r_state == ST_IDLE) && i_cmd_valid;
        o_div.start = 1'b0;
        o_div.num   = '0;
        o_div.den   = 64'd1;
        case (r_state)
            ST_AX1: begin
                o_div.start = !r_wait;
                o_div.num   = {34'd0, prod48};
                o_div.den   = {56'd0, i_cfg.clock_mhz};
            end
            ST_ANG: begin
                o_div.start = !r_wait;
                o_div.num   = {24'd0, g_sel, 16'd0};
                o_div.den   = {40'd0, cp};
            end
            ST_TDIV: begin
                o_div.start = !r_wait;
                o_div.num   = {8'd0, w_sel, 32'd0};
                o_div.den   = {56'd0, i_cfg.clock_mhz};
            end
            ST_ODIV: begin
                o_div.start = !r_wait;
                o_div.num   = offn;
                o_div.den   = {48'd0, i_cfg.period_us};
            end
            ST_QDIV: begin
                o_div.start = !r_wait;
                o_div.num   = c1n;
                o_div.den   = r_d;
            end
            default: begin
                o_div.start = 1'b0;
            end
        endcase
    end

    assign o_fix.valid       = r_out_valid;
    assign o_fix.fix_valid   = r_out.fix_valid;
    assign o_fix.azimuth     = r_out.azimuth;
    assign o_fix.elevation   = r_out.elevation;
    assign o_fix.range_horiz = r_out.range_horiz;
    assign o_fix.range_vert  = r_out.range_vert;
    assign o_fix.slot_echo   = r_out.slot_echo;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_wslot     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_div.start)     r_wait <= 1'b1;
            else if (i_div.done) r_wait <= 1'b0;
            if (o_cmd_pop && i_cmd.op == OP_PULSE) begin
                r_ring[r_wslot] <= {i_cmd.fall, i_cmd.rise};
                r_wslot <= (r_wslot == WIN_AW'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_fix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- walk and arithmetic registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ptr   <= r_wslot;
                r_idx   <= '0;
                r_first <= WIN_CW'(WINDOW);
                r_ok    <= 1'b1;
                r_sum   <= '0;
                r_vert  <= 1'b0;
                r_slot  <= i_cmd.slot;
            end
            ST_CLS: begin
                r_cur_w <= w_cur;
                r_cur_g <= g_cur;
                r_cur_f <= e_fall;
                if (!is_sweep && !is_sync) begin
                    r_ok <= 1'b0;
                end else if (is_sweep && has_first) begin
                    if (!k_ok) r_ok <= 1'b0;
                end else begin
                    if (is_sync && !has_first) r_first <= r_idx;
                    r_prev_w <= w_cur;
                    r_prev_f <= e_fall;
                    r_idx    <= r_idx + 1'b1;
                    r_ptr    <= (r_ptr == WIN_AW'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
                end
            end
            ST_AX1: begin
                if (i_div.done) begin
                    if (q < AXIS_BASE)          r_v <= '0;
                    else if (vq > ANGLE_MAX)    r_v <= 16'hFFFF;
                    else                        r_v <= vq[15:0];
                end
            end
            ST_AX2: begin
                if (ax == 2'd1) begin
                    r_gh <= r_cur_g;
                    r_wh <= r_cur_w;
                end else begin
                    r_gv <= r_cur_g;
                    r_wv <= r_cur_w;
                end
                r_sum    <= r_sum + {1'b0, ax};
                r_prev_w <= r_cur_w;
                r_prev_f <= r_cur_f;
                r_idx    <= r_idx + 1'b1;
                r_ptr    <= (r_ptr == WIN_AW'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
            end
            ST_CHK: begin
                r_ok <= final_ok;
            end
            ST_ANG: begin
                if (i_div.done) begin
                    if (r_vert) r_el <= (q > ANGLE_MAX) ? 16'hFFFF : q[15:0];
                    else        r_az <= (q > ANGLE_MAX) ? 16'hFFFF : q[15:0];
                end
            end
            ST_TDIV: begin
                if (i_div.done) r_t <= q;
            end
            ST_ODIV: begin
                if (i_div.done) begin
                    r_d   <= d_val;
                    r_neg <= d_neg;
                    if (d_zero) begin
                        if (r_vert) r_rv <= STAMP_MAX;
                        else        r_rh <= STAMP_MAX;
                        r_vert <= 1'b1;
                    end
                end
            end
            ST_QDIV: begin
                if (i_div.done) begin
                    if (r_vert) r_rv <= (rr > RANGE_MAX) ? STAMP_MAX : rr[23:0];
                    else        r_rh <= (rr > RANGE_MAX) ? STAMP_MAX : rr[23:0];
                    r_vert <= 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out.fix_valid   <= r_ok;
                    r_out.azimuth     <= r_ok ? r_az : '0;
                    r_out.elevation   <= r_ok ? r_el : '0;
                    r_out.range_horiz <= r_ok ? r_rh : '0;
                    r_out.range_vert  <= r_ok ? r_rv : '0;
                    r_out.slot_echo   <= r_slot;
                end
            end
            default: begin
                r_ok <= r_ok;
            end
        endcase
    end

endmodule

[rtl/lpl_chk.sv]
// ----------------------------------------------------------------------------
// lpl_chk
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module lpl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_fix_valid,
    input logic [15:0] i_azimuth,
    input logic [15:0] i_elevation,
    input logic [23:0] i_range_horiz,
    input logic [23:0] i_range_vert,
    input logic [39:0] i_slot_echo
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result beat dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_slot_echo) && $stable(i_fix_valid))
        else $error("stalled result changed");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_fix_valid |-> i_azimuth == '0 && i_elevation == '0 &&
            i_range_horiz == '0 && i_range_vert == '0)
        else $error("invalid fix carries nonzero fields");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind lighthouse_pulse_localizer_unit lpl_chk u_lpl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_fix.valid),
    .i_ready       (o_fix.ready),
    .i_fix_valid   (o_fix.fix_valid),
    .i_azimuth     (o_fix.azimuth),
    .i_elevation   (o_fix.elevation),
    .i_range_horiz (o_fix.range_horiz),
    .i_range_vert  (o_fix.range_vert),
    .i_slot_echo   (o_fix.slot_echo)
);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lighthouse_pulse_localizer_unit. A directed table
// covers the ring's reset state, stamp extremes, wraparound and invalid
// widths. Random phases follow, each under its own register setting. They
// send pulse windows shaped to give a fix, mixed with noise beats. Fix beats
// are compared field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
    import lpl_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 200;
    localparam int STALL_LIMIT = 20000;   // idle cycles before the bench gives up
    localparam int HOLD_CYCLES = 3000;    // long receiver hold-off
    localparam int SETTLE      = 100;     // pulse beats finish well inside this

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    lpl_in_if  beat_in();
    lpl_out_if fix_out();

    lighthouse_pulse_localizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pulse (beat_in),
        .o_fix   (fix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // ---------------------------------------------------------------- predictor
    // Own copy of the registers and the pulse ring, updated on accepted beats.
    logic [7:0]  cfg_clock;
    logic [9:0]  cfg_min_sync;
    logic [9:0]  cfg_max_sync;
    logic [15:0] cfg_period;
    logic [23:0] ring_rise [WINDOW];
    logic [23:0] ring_fall [WINDOW];
    int          wr_slot;

    t_fix fix_queue[$];          // fixes still owed by the block
    int   errors;
    int   in_idle_pct, out_stall_pct;
    bit   hold_req, hold_done;
    bit   in_acc, out_acc;

    function automatic logic [31:0] eff_clock();
        return (cfg_clock == 0) ? 32'd1 : 32'(cfg_clock);
    endfunction

    function automatic logic [31:0] eff_period();
        return (cfg_period == 0) ? 32'd1 : 32'(cfg_period);
    endfunction

    // 24-bit tick distance; a wrap loses one tick
    function automatic logic [31:0] tick_span(logic [23:0] a, logic [23:0] b);
        if (a > b)
            return 32'(b) + (32'hFFFFFF - 32'(a));
        return 32'(b) - 32'(a);
    endfunction

    // stamp b such that tick_span(a, b) == d
    function automatic logic [23:0] stamp_after(logic [23:0] a, logic [31:0] d);
        logic [31:0] s;
        s = 32'(a) + d;
        if (s > 32'hFFFFFF)
            s = s + 1 - 32'h1000000;
        return s[23:0];
    endfunction

    // sync width -> 1 horizontal, 2 vertical
    function automatic int sweep_axis(logic [31:0] w);
        logic [63:0] v;
        v = (64'(w) * 64'd48) / 64'(eff_clock());
        v = (v < 64'd2501) ? 64'd0 : v - 64'd2501;
        if (v > 64'd65535)
            v = 64'd65535;
        return 1 + int'((v / 64'd500) & 64'd1);
    endfunction

    function automatic logic [15:0] sweep_angle(logic [31:0] g);
        logic [63:0] a;
        a = (64'(g) << 16) / (64'(eff_clock()) * 64'(eff_period()));
        return (a > 64'd65535) ? 16'hFFFF : a[15:0];
    endfunction

    function automatic logic [23:0] sweep_range(logic [31:0] w, bit vert);
        logic [63:0] t, o, c1, e, d, q, r;
        bit neg;
        t   = (64'(w) << 32) / 64'(eff_clock());
        o   = ((vert ? 64'd58989 : 64'd19818) * 64'd205887) / 64'(eff_period());
        c1  = vert ? 64'd1061080 : 64'd1199250;
        e   = vert ? 64'd20146 : 64'd14536;
        neg = 1'b0;
        if (!vert)
            d = t + o;
        else if (t >= o)
            d = t - o;
        else begin
            d   = o - t;
            neg = 1'b1;
        end
        if (d == 0)
            return 24'hFFFFFF;          // zero divisor saturates
        q = (c1 << 32) / d;
        if (neg)
            r = (q >= e) ? 64'd0 : e - q;
        else
            r = e + q;
        return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
    endfunction

    // Walk the ring oldest to newest and build the fix for one request.
    function automatic t_fix predict_fix(logic [39:0] slot);
        logic [23:0] r [WINDOW];
        logic [23:0] f [WINDOW];
        int          kind [WINDOW];
        int          first, sum, i, k, ax;
        bit          ok;
        logic [31:0] w, lo, hi;
        t_fix        fx;
        fx    = '0;
        first = WINDOW;
        sum   = 0;
        ok    = 1'b1;
        lo    = 32'(cfg_min_sync) * eff_clock();
        hi    = 32'(cfg_max_sync) * eff_clock();
        for (i = 0; i < WINDOW; i++) begin
            r[i]    = ring_rise[(wr_slot + i) % WINDOW];
            f[i]    = ring_fall[(wr_slot + i) % WINDOW];
            kind[i] = 0;
        end
        for (i = 0; i < WINDOW && ok; i++) begin
            w = tick_span(r[i], f[i]);
            if (w < lo) begin
                if (first != WINDOW) begin
                    k  = i - first;
                    ax = sweep_axis(tick_span(r[i-1], f[i-1]));
                    if (k == 1 || k == 3) begin
                        kind[i] = ax;
                        sum    += ax;
                    end else
                        ok = 1'b0;
                end
            end else if (w < hi) begin
                if (first == WINDOW)
                    first = i;
            end else
                ok = 1'b0;
        end
        if (first == WINDOW || sum != 3)
            ok = 1'b0;
        if (ok) begin
            for (i = first + 1; i < WINDOW; i++) begin
                if (kind[i] == 1) begin
                    fx.azimuth     = sweep_angle(tick_span(f[i-1], r[i]));
                    fx.range_horiz = sweep_range(tick_span(r[i], f[i]), 1'b0);
                end else if (kind[i] == 2) begin
                    fx.elevation  = sweep_angle(tick_span(f[i-1], r[i]));
                    fx.range_vert = sweep_range(tick_span(r[i], f[i]), 1'b1);
                end
            end
        end
        fx.fix_valid = ok;
        fx.slot_echo = slot;
        return fx;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Fix beats: sampled at the edge, so values are those before the edge.
    always @(posedge i_clk) begin
        t_fix got, want;
        out_acc = fix_out.valid && fix_out.ready && i_rst_n;
        if (out_acc) begin
            got = '{fix_out.fix_valid, fix_out.azimuth, fix_out.elevation,
                    fix_out.range_horiz, fix_out.range_vert, fix_out.slot_echo};
            if (fix_queue.size() == 0)
                report("unexpected fix beat", got.slot_echo, 0);
            else begin
                want = fix_queue.pop_front();
                if (got.fix_valid != want.fix_valid)
                    report("fix_valid", got.fix_valid, want.fix_valid);
                if (got.azimuth != want.azimuth)
                    report("azimuth", got.azimuth, want.azimuth);
                if (got.elevation != want.elevation)
                    report("elevation", got.elevation, want.elevation);
                if (got.range_horiz != want.range_horiz)
                    report("range_horiz", got.range_horiz, want.range_horiz);
                if (got.range_vert != want.range_vert)
                    report("range_vert", got.range_vert, want.range_vert);
                if (got.slot_echo != want.slot_echo)
                    report("slot_echo", got.slot_echo, want.slot_echo);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done)
            fix_out.ready <= 1'b0;
        else
            fix_out.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    initial begin
        wait (hold_req);
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_done = 1'b1;
    end

    // Watchdog: too long without any beat or register write means a hang.
    always @(posedge i_clk) begin
        int quiet;
        in_acc = beat_in.valid && beat_in.ready && i_rst_n;
        if (in_acc || fix_out.valid && fix_out.ready || psel || !i_rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers
    task automatic reg_write(t_reg idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CLOCK:    cfg_clock    = val[7:0];
            REG_MIN_SYNC: cfg_min_sync = val[9:0];
            REG_MAX_SYNC: cfg_max_sync = val[9:0];
            REG_PERIOD:   cfg_period   = val[15:0];
            default:      ;
        endcase
    endtask

    // One input beat. no_fix: the expected result is the plain no-fix one.
    task automatic send_beat(t_op op, logic [23:0] rise, logic [23:0] fall,
                             logic [39:0] slot, bit no_fix);
        t_fix fx;
        while ($urandom_range(99) < in_idle_pct) begin
            beat_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        beat_in.valid       <= 1'b1;
        beat_in.func        <= op;
        beat_in.rise_ticks  <= rise;
        beat_in.fall_ticks  <= fall;
        beat_in.slot_number <= slot;
        do @(posedge i_clk); while (!(beat_in.valid && beat_in.ready));
        if (op == OP_PULSE) begin
            ring_rise[wr_slot] = rise;
            ring_fall[wr_slot] = fall;
            wr_slot = (wr_slot + 1) % WINDOW;
        end else begin
            if (no_fix) begin
                fx = '0;
                fx.slot_echo = slot;
            end else
                fx = predict_fix(slot);
            fix_queue.push_back(fx);
        end
    endtask

    task automatic drain();
        beat_in.valid <= 1'b0;
        while (fix_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [39:0] rand_slot();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [31:0] rand_between(logic [31:0] lo, logic [31:0] hi);
        return (hi <= lo) ? lo : $urandom_range(hi, lo);
    endfunction

    // Five pulses laid out as S W S W S or W S W S W, then a request.
    // Sync widths are picked for one horizontal and one vertical sweep,
    // with the odd broken layout mixed in.
    task automatic send_window(output int beats);
        logic [31:0] lo, hi, w, g, gmax;
        logic [23:0] cur, rise, fall;
        bit          lead_sweep, is_sync;
        int          want_ax, i, tries;
        lo         = 32'(cfg_min_sync) * eff_clock();
        hi         = 32'(cfg_max_sync) * eff_clock();
        gmax       = eff_clock() * eff_period();
        if (gmax > 32'h7FFFFF)
            gmax = 32'h7FFFFF;
        lead_sweep = $urandom_range(1);
        want_ax    = $urandom_range(1, 2);
        cur        = 24'($urandom);
        for (i = 0; i < WINDOW; i++) begin
            is_sync = lead_sweep ? (i % 2 == 1) : (i % 2 == 0);
            if ($urandom_range(19) == 0)
                is_sync = !is_sync;                 // broken order
            if (is_sync) begin
                tries = 0;
                do begin
                    w = rand_between(lo, hi - 1);
                    tries++;
                end while (sweep_axis(w) != want_ax && tries < 20);
                want_ax = 3 - want_ax;
                g = $urandom_range(100000);
            end else begin
                w = (lo == 0) ? 0 : $urandom_range(lo - 1);
                g = rand_between(0, gmax);
            end
            rise = stamp_after(cur, g);
            fall = stamp_after(rise, w);
            cur  = fall;
            send_beat(OP_PULSE, rise, fall, rand_slot(), 1'b0);
        end
        send_beat(OP_LOCATE, 24'($urandom), 24'($urandom), rand_slot(), 1'b0);
        beats = WINDOW + 1;
    endtask

    // ---------------------------------------------------------------- stimulus
    typedef struct {
        t_op         op;
        logic [23:0] rise;
        logic [23:0] fall;
        logic [39:0] slot;
        bit          no_fix;   // result known at a glance: no fix, slot echoed
    } t_row;

    // Reset settings: sync widths 1600..4479 ticks.
    // 2000 ticks decodes horizontal, 2062 and 2100 vertical.
    t_row directed [17] = '{
        '{OP_LOCATE, 24'h000000, 24'h000000, 40'h00_0000_0000, 1'b1}, // ring empty
        '{OP_LOCATE, 24'hFFFFFF, 24'hFFFFFF, 40'hFF_FFFF_FFFF, 1'b1},
        '{OP_PULSE,  24'hFFFFFF, 24'h000000, 40'h00_0000_0000, 1'b0}, // zero width on wrap
        '{OP_PULSE,  24'h000000, 24'hFFFFFF, 40'hFF_FFFF_FFFF, 1'b0}, // widest: invalid
        '{OP_LOCATE, 24'h000000, 24'h000000, 40'h55_5555_5555, 1'b1},
        '{OP_PULSE,  24'd1000,   24'd3000,   40'd1,            1'b0}, // sync, horiz
        '{OP_PULSE,  24'd5000,   24'd5100,   40'd2,            1'b0}, // sweep
        '{OP_PULSE,  24'd10000,  24'd12100,  40'd3,            1'b0}, // sync, vert
        '{OP_PULSE,  24'd20000,  24'd20200,  40'd4,            1'b0}, // sweep
        '{OP_PULSE,  24'd30000,  24'd33000,  40'd5,            1'b0}, // trailing sync
        '{OP_LOCATE, 24'h000000, 24'h000000, 40'hAA_AAAA_AAAA, 1'b0},
        '{OP_PULSE,  24'hFFFF00, 24'hFFFF80, 40'd6,            1'b0}, // sweep before sync
        '{OP_PULSE,  24'hFFFFC0, 24'h0007CF, 40'd7,            1'b0}, // sync across wrap
        '{OP_PULSE,  24'h001000, 24'h001040, 40'd8,            1'b0},
        '{OP_PULSE,  24'h002000, 24'h0027D0, 40'd9,            1'b0},
        '{OP_PULSE,  24'h004000, 24'h004010, 40'd10,           1'b0},
        '{OP_LOCATE, 24'hFFFFFF, 24'h000000, 40'h12_3456_789A, 1'b0}
    };

    initial begin
        int p, n, beats;
        logic [31:0] settings [4];
        errors        = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        wr_slot       = 0;
        cfg_clock     = 8'd32;
        cfg_min_sync  = 10'd50;
        cfg_max_sync  = 10'd140;
        cfg_period    = 16'd8333;
        for (int i = 0; i < WINDOW; i++) begin
            ring_rise[i] = '0;
            ring_fall[i] = '0;
        end
        i_rst_n             = 1'b0;
        beat_in.valid       = 1'b0;
        beat_in.func        = OP_PULSE;
        beat_in.rise_ticks  = '0;
        beat_in.fall_ticks  = '0;
        beat_in.slot_number = '0;
        fix_out.ready       = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_beat(directed[i].op, directed[i].rise, directed[i].fall,
                      directed[i].slot, directed[i].no_fix);

        for (p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: settings = '{32, 50, 140, 8333};     // defaults, written back
                1: settings = '{255, 1023, 1023, 65535};
                2: settings = '{0, 0, 0, 0};            // nothing narrow, all invalid
                3: settings = '{0, 50, 140, 0};         // zero clock and period
                4: settings = '{1, 1, 1023, 1};
                default: begin
                    settings[0] = $urandom_range(255);
                    settings[1] = $urandom_range(1023);
                    settings[2] = $urandom_range(1023, settings[1]);
                    settings[3] = $urandom_range(65535);
                end
            endcase
            reg_write(REG_CLOCK,    settings[0]);
            reg_write(REG_MIN_SYNC, settings[1]);
            reg_write(REG_MAX_SYNC, settings[2]);
            reg_write(REG_PERIOD,   settings[3]);
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 50; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 50; end
                default: begin in_idle_pct = 13; out_stall_pct = 13; end
            endcase
            if (p == 1)
                hold_req = 1'b1;        // block fills up and stalls its input
            n = 0;
            while (n < PHASE_BEATS) begin
                if (p == 3 && n >= PHASE_BEATS / 2 && n < PHASE_BEATS / 2 + 6)
                    drain();            // sender waits out every fix
                if ($urandom_range(3) != 0)
                    send_window(beats);
                else begin
                    send_beat(($urandom_range(9) < 3) ? OP_LOCATE : OP_PULSE,
                              24'($urandom), 24'($urandom), rand_slot(), 1'b0);
                    beats = 1;
                end
                n += beats;
            end
        end

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
